// ===== src/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants for the command frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

	// bytes kept per frame; the opening byte is entry 0
	localparam int FRAME_BYTES = 12;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	// count runs up to FRAME_BYTES+1 for an overlong frame
	localparam int COUNT_W     = $clog2(FRAME_BYTES + 2);

	localparam logic [7:0] BYTE_OPEN  = 8'h01;
	localparam logic [7:0] BYTE_CLOSE = 8'hFE;

	typedef enum logic [1:0] {
		CMD_SET_TIME = 2'd0,
		CMD_TEMP_REF = 2'd1,
		CMD_REQ_MEAS = 2'd2,
		CMD_ERASE    = 2'd3
	} cmd_t;

	// stored bytes the decoder looks at, with the frame length
	typedef struct packed {
		logic [7:0]         cmd_byte;
		logic [COUNT_W-1:0] len;
		logic [7:0]         b3;
		logic [7:0]         b4;
		logic [7:0]         b5;
		logic [7:0]         b6;
		logic [7:0]         b7;
		logic [7:0]         b9;
		logic [7:0]         b10;
	} frame_view_t;

	typedef struct packed {
		logic        frame_ok;
		cmd_t        command;
		logic [15:0] hour;
		logic [15:0] minute;
		logic [15:0] second;
		logic [15:0] temp_tenths;
	} frame_result_t;

endpackage

// ===== src/command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// command_frame_parser
// Assembles command frames from a received byte stream and decodes them.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one received byte per
//   transaction. 0x01 opens a frame, 0xFE closes it. Each closing byte in
//   an open frame gives one transaction on the result channel
//   (res_valid/res_ready) carrying frame_ok, command and the decoded time or
//   temperature fields; all other bytes give none.
//   Throughput: one byte per cycle, sustained while rx_ready stays high (see
//   Stall). A closing byte passes the input register, then frame state
//   update and decode into the result register.
//   Stall: while a result waits on res_ready, the input register still
//   advances over bytes that close no frame; a second closing byte holds in
//   the input register and rx_ready drops until the waiting result is taken.
//   Reset: no frame open, byte count zero, both channels empty. The frame
//   buffer is not cleared; fields are only decoded from bytes the current
//   frame wrote.
// ----------------------------------------------------------------------------
module command_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               frame_ok,
	output logic [1:0]         command,
	output logic [15:0]        hour,
	output logic [15:0]        minute,
	output logic [15:0]        second,
	output logic signed [15:0] temp_tenths
);
	import cfp_pkg::*;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                in_frame_q;
	logic [COUNT_W-1:0]  count_q;
	logic [7:0]          store_q [FRAME_BYTES];
	logic                res_valid_q;
	frame_result_t       result_s2;

	logic                active;
	logic                close_hit;
	logic                room;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [COUNT_W-1:0]  count_next;
	logic                s1_fire;
	logic [7:0]          view_byte [FRAME_BYTES];
	frame_view_t         view;
	frame_result_t       dec_result;

	// input register
	assign rx_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame tracking
	always_comb begin
		active     = valid_s1 && (in_frame_q || byte_s1 == BYTE_OPEN);
		close_hit  = active && byte_s1 == BYTE_CLOSE;
		room       = count_q < COUNT_W'(FRAME_BYTES);
		wr_en      = active && room;
		wr_idx     = count_q[IDX_W-1:0];
		count_next = room ? count_q + COUNT_W'(1) : COUNT_W'(FRAME_BYTES + 1);
		// hold a closing byte while the previous result is still waiting
		s1_fire    = valid_s1 && (!close_hit || !res_valid_q || res_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
		end else if (s1_fire && active) begin
			if (close_hit) begin
				in_frame_q <= 1'b0;
				count_q    <= '0;
			end else begin
				in_frame_q <= 1'b1;
				count_q    <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && wr_en) begin
			store_q[wr_idx] <= byte_s1;
		end
	end

	// buffer as it stands once this byte is written
	always_comb begin
		for (int i = 0; i < FRAME_BYTES; i++) begin
			view_byte[i] = (wr_en && wr_idx == IDX_W'(i)) ? byte_s1 : store_q[i];
		end
		view.cmd_byte = view_byte[1];
		view.len      = count_next;
		view.b3       = view_byte[3];
		view.b4       = view_byte[4];
		view.b5       = view_byte[5];
		view.b6       = view_byte[6];
		view.b7       = view_byte[7];
		view.b9       = view_byte[9];
		view.b10      = view_byte[10];
	end

	cfp_decode u_decode (
		.view   (view),
		.result (dec_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && close_hit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && close_hit) begin
			result_s2 <= dec_result;
		end
	end

	assign res_valid   = res_valid_q;
	assign frame_ok    = result_s2.frame_ok;
	assign command     = result_s2.command;
	assign hour        = result_s2.hour;
	assign minute      = result_s2.minute;
	assign second      = result_s2.second;
	assign temp_tenths = $signed(result_s2.temp_tenths);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(FRAME_BYTES + 1))
		else $error("byte count beyond saturation value");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> count_q == '0)
		else $error("byte count nonzero outside a frame");

	a_close_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && close_hit |=> res_valid)
		else $error("closing byte did not produce a result");

	a_bad_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !frame_ok |-> command == CMD_SET_TIME && hour == 16'h0000 &&
			minute == 16'h0000 && second == 16'h0000 && temp_tenths == 16'sh0000)
		else $error("invalid frame carries nonzero fields");

	a_time_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && command != CMD_SET_TIME |->
			hour == 16'h0000 && minute == 16'h0000 && second == 16'h0000)
		else $error("time fields set for a non-time command");

endmodule

// ===== src/cfp_decode.sv =====
// ----------------------------------------------------------------------------
// cfp_decode
// Checks command against frame length and converts the ASCII digit fields.
// ----------------------------------------------------------------------------
module cfp_decode (
	input  cfp_pkg::frame_view_t   view,
	output cfp_pkg::frame_result_t result
);
	import cfp_pkg::*;

	localparam logic [7:0] CODE_SET_TIME = 8'h20;
	localparam logic [7:0] CODE_TEMP_REF = 8'h25;
	localparam logic [7:0] CODE_REQ_MEAS = 8'h55;
	localparam logic [7:0] CODE_ERASE    = 8'h60;

	localparam logic [COUNT_W-1:0] LEN_SET_TIME = COUNT_W'(12);
	localparam logic [COUNT_W-1:0] LEN_TEMP_REF = COUNT_W'(8);
	localparam logic [COUNT_W-1:0] LEN_SHORT    = COUNT_W'(4);

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_DOT  = 8'h2E;

	// tens*10+units, wrapping modulo 2^16
	function automatic logic [15:0] digit_pair(input logic [7:0] tens,
	                                           input logic [7:0] units);
		logic [15:0] t;
		logic [15:0] u;
		t = {8'h00, tens} - {8'h00, ASCII_ZERO};
		u = {8'h00, units} - {8'h00, ASCII_ZERO};
		return (t << 3) + (t << 1) + u;
	endfunction

	logic [15:0] temp_int;
	logic [15:0] temp_frac;
	logic [15:0] temp_val;

	always_comb begin
		temp_int  = digit_pair(view.b3, view.b4);
		temp_frac = (view.b5 == ASCII_DOT) ?
			({8'h00, view.b6} - {8'h00, ASCII_ZERO}) : 16'h0000;
		temp_val  = (temp_int << 3) + (temp_int << 1) + temp_frac;
	end

	always_comb begin
		result = '0;
		result.command = CMD_SET_TIME;
		unique case (view.cmd_byte)
			CODE_SET_TIME: begin
				if (view.len == LEN_SET_TIME) begin
					result.frame_ok = 1'b1;
					result.command  = CMD_SET_TIME;
					result.hour     = digit_pair(view.b3, view.b4);
					result.minute   = digit_pair(view.b6, view.b7);
					result.second   = digit_pair(view.b9, view.b10);
				end
			end
			CODE_TEMP_REF: begin
				if (view.len == LEN_TEMP_REF) begin
					result.frame_ok    = 1'b1;
					result.command     = CMD_TEMP_REF;
					result.temp_tenths = temp_val;
				end
			end
			CODE_REQ_MEAS: begin
				if (view.len == LEN_SHORT) begin
					result.frame_ok = 1'b1;
					result.command  = CMD_REQ_MEAS;
				end
			end
			CODE_ERASE: begin
				if (view.len == LEN_SHORT) begin
					result.frame_ok = 1'b1;
					result.command  = CMD_ERASE;
				end
			end
			default: begin
				result.frame_ok = 1'b0;
			end
		endcase
	end

endmodule

// ===== tb/command_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// command_frame_parser_tb
// Self-checking bench for the command frame parser. It drives received bytes
// on the rx channel and tracks frame state in its own decoder. Every closing
// byte of an open frame queues one expected result, and each result
// transaction is checked field by field against the oldest entry. It starts
// with a table of fixed frames, then sends mostly well-formed frames with
// random content, mixed with broken and overlong frames and noise between
// frames. Both channels idle at random.
// ----------------------------------------------------------------------------
module command_frame_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfp_pkg::*;

	localparam int          BYTE_TARGET    = 1050;
	localparam int          CYCLE_LIMIT    = 200000;
	localparam int          DRAIN_CYCLES   = 20;

	localparam logic [7:0]  CMD_BYTE_TIME  = 8'h20;
	localparam logic [7:0]  CMD_BYTE_TEMP  = 8'h25;
	localparam logic [7:0]  CMD_BYTE_MEAS  = 8'h55;
	localparam logic [7:0]  CMD_BYTE_ERASE = 8'h60;
	localparam int          LEN_TIME       = 12;
	localparam int          LEN_TEMP       = 8;
	localparam int          LEN_SHORT      = 4;
	localparam logic [7:0]  ASCII_ZERO     = 8'h30;
	localparam logic [7:0]  ASCII_DOT      = 8'h2E;
	localparam logic [7:0]  ASCII_COLON    = 8'h3A;

	localparam frame_result_t RES_NONE  = '{1'b0, CMD_SET_TIME, 16'd0, 16'd0, 16'd0, 16'd0};
	localparam frame_result_t RES_ERASE = '{1'b1, CMD_ERASE, 16'd0, 16'd0, 16'd0, 16'd0};
	localparam frame_result_t RES_MEAS  = '{1'b1, CMD_REQ_MEAS, 16'd0, 16'd0, 16'd0, 16'd0};
	localparam frame_result_t RES_TEMP_MAX =
		'{1'b1, CMD_TEMP_REF, 16'd0, 16'd0, 16'd0, 16'd22977};

	typedef struct packed {
		logic [7:0]    rx;
		logic          typed;
		frame_result_t res;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               rx_valid;
	logic               rx_ready;
	logic [7:0]         rx_byte;
	logic               res_valid;
	logic               res_ready;
	logic               frame_ok;
	logic [1:0]         command;
	logic [15:0]        hour;
	logic [15:0]        minute;
	logic [15:0]        second;
	logic signed [15:0] temp_tenths;

	// decoder state
	bit                 frame_open;
	int unsigned        frame_len;
	logic [7:0]         frame_bytes [FRAME_BYTES];

	frame_result_t      pending_results [$];
	logic [7:0]         frame_queue [$];
	stim_row_t          directed_rows [$];
	int unsigned        error_count;
	int unsigned        cycle_count;
	bit                 steady;

	command_frame_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.frame_ok    (frame_ok),
		.command     (command),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.temp_tenths (temp_tenths)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("command_frame_parser regression: fail");
			$finish;
		end
	end

	function automatic int unsigned idle_cycles();
		return steady ? 0 : $urandom_range(0, 8);
	endfunction

	// two ASCII digits as tens and units, 16-bit wrap
	function automatic logic [15:0] digit_pair(input logic [7:0] tens, input logic [7:0] units);
		return ({8'h00, tens} - {8'h00, ASCII_ZERO}) * 16'd10
			+ ({8'h00, units} - {8'h00, ASCII_ZERO});
	endfunction

	task automatic track_frame_byte(input logic [7:0] b, output bit has_res,
			output frame_result_t res);
		int unsigned len;
		logic [7:0]  cmd_byte;
		has_res = 1'b0;
		res = RES_NONE;
		if (b == BYTE_OPEN)
			frame_open = 1'b1;
		if (!frame_open)
			return;
		if (frame_len < FRAME_BYTES) begin
			frame_bytes[frame_len] = b;
			frame_len++;
		end else begin
			frame_len = FRAME_BYTES + 1;
		end
		if (b != BYTE_CLOSE)
			return;
		len = frame_len;
		cmd_byte = frame_bytes[1];
		frame_open = 1'b0;
		frame_len = 0;
		has_res = 1'b1;
		res.frame_ok = 1'b1;
		if (cmd_byte == CMD_BYTE_TIME && len == LEN_TIME) begin
			res.command = CMD_SET_TIME;
			res.hour    = digit_pair(frame_bytes[3], frame_bytes[4]);
			res.minute  = digit_pair(frame_bytes[6], frame_bytes[7]);
			res.second  = digit_pair(frame_bytes[9], frame_bytes[10]);
		end else if (cmd_byte == CMD_BYTE_TEMP && len == LEN_TEMP) begin
			res.command = CMD_TEMP_REF;
			res.temp_tenths = digit_pair(frame_bytes[3], frame_bytes[4]) * 16'd10;
			// tenth digit only when a decimal point precedes it
			if (frame_bytes[5] == ASCII_DOT)
				res.temp_tenths += {8'h00, frame_bytes[6]} - {8'h00, ASCII_ZERO};
		end else if (cmd_byte == CMD_BYTE_MEAS && len == LEN_SHORT) begin
			res.command = CMD_REQ_MEAS;
		end else if (cmd_byte == CMD_BYTE_ERASE && len == LEN_SHORT) begin
			res.command = CMD_ERASE;
		end else begin
			res = RES_NONE;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t typed_res);
		int unsigned   gap;
		bit            has_res;
		frame_result_t res;
		gap = idle_cycles();
		if (gap != 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!rx_ready) @(posedge clk);
		track_frame_byte(b, has_res, res);
		if (has_res)
			pending_results.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	// content byte: mostly ASCII digits, never a closing byte
	function automatic logic [7:0] payload_byte();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0: b = 8'h00;
			1: b = 8'hFF;
			2: b = 8'($urandom_range(0, 255));
			default: b = ASCII_ZERO + 8'($urandom_range(0, 9));
		endcase
		return (b == BYTE_CLOSE) ? ASCII_COLON : b;
	endfunction

	// build one random frame, or noise between frames; returns bytes that count
	task automatic fill_random_frame(output int unsigned counted);
		int unsigned n;
		logic [7:0]  cmd_byte;
		frame_queue.delete();
		case ($urandom_range(0, 9))
			0, 1: begin
				frame_queue.push_back(BYTE_OPEN);
				frame_queue.push_back(CMD_BYTE_TIME);
				repeat (LEN_TIME - 3) frame_queue.push_back(payload_byte());
			end
			2, 3: begin
				frame_queue.push_back(BYTE_OPEN);
				frame_queue.push_back(CMD_BYTE_TEMP);
				repeat (3) frame_queue.push_back(payload_byte());
				frame_queue.push_back($urandom_range(0, 1) ? ASCII_DOT : payload_byte());
				frame_queue.push_back(payload_byte());
			end
			4, 5: begin
				frame_queue.push_back(BYTE_OPEN);
				frame_queue.push_back($urandom_range(0, 1) ? CMD_BYTE_MEAS : CMD_BYTE_ERASE);
				frame_queue.push_back(payload_byte());
			end
			6, 7, 8: begin
				// mostly wrong length, unknown command or overlong
				case ($urandom_range(0, 4))
					0: cmd_byte = CMD_BYTE_TIME;
					1: cmd_byte = CMD_BYTE_TEMP;
					2: cmd_byte = CMD_BYTE_MEAS;
					3: cmd_byte = CMD_BYTE_ERASE;
					default: cmd_byte = 8'($urandom_range(0, 255));
				endcase
				frame_queue.push_back(BYTE_OPEN);
				frame_queue.push_back(cmd_byte);
				n = $urandom_range(0, 14);
				repeat (n) frame_queue.push_back(payload_byte());
			end
			default: begin
				// noise outside a frame, stray closing bytes included
				n = $urandom_range(1, 4);
				repeat (n) begin
					cmd_byte = 8'($urandom_range(0, 255));
					frame_queue.push_back((cmd_byte == BYTE_OPEN) ? BYTE_CLOSE : cmd_byte);
				end
				counted = 0;
				return;
			end
		endcase
		frame_queue.push_back(BYTE_CLOSE);
		counted = frame_queue.size();
	endtask

	function automatic stim_row_t row(input logic [7:0] b);
		return '{b, 1'b0, RES_NONE};
	endfunction

	function automatic stim_row_t row_res(input logic [7:0] b, input frame_result_t r);
		return '{b, 1'b1, r};
	endfunction

	// result side: random stalls, check every transaction
	initial begin
		int unsigned   gap;
		frame_result_t want;
		res_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = idle_cycles();
			if (gap != 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!(res_valid && res_ready)) @(posedge clk);
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (frame_ok !== want.frame_ok) begin
					$error("frame_ok: expected %0d, got %0d", want.frame_ok, frame_ok);
					error_count++;
				end
				if (command !== want.command) begin
					$error("command: expected %0d, got %0d", want.command, command);
					error_count++;
				end
				if (hour !== want.hour) begin
					$error("hour: expected %0d, got %0d", want.hour, hour);
					error_count++;
				end
				if (minute !== want.minute) begin
					$error("minute: expected %0d, got %0d", want.minute, minute);
					error_count++;
				end
				if (second !== want.second) begin
					$error("second: expected %0d, got %0d", want.second, second);
					error_count++;
				end
				if (temp_tenths !== want.temp_tenths) begin
					$error("temp_tenths: expected %0d, got %0d",
						$signed(want.temp_tenths), temp_tenths);
					error_count++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		int unsigned sent;
		int unsigned counted;
		arst_n      = 1'b0;
		rx_valid    = 1'b0;
		rx_byte     = 8'h00;
		error_count = 0;
		cycle_count = 0;
		steady      = 1'b0;
		frame_open  = 1'b0;
		frame_len   = 0;
		foreach (frame_bytes[i])
			frame_bytes[i] = 8'h00;

		directed_rows = '{
			// stray bytes before any frame are dropped
			row(BYTE_CLOSE), row(8'hFF),
			row(BYTE_OPEN), row(CMD_BYTE_ERASE), row(8'h00), row_res(BYTE_CLOSE, RES_ERASE),
			row(BYTE_OPEN), row(CMD_BYTE_MEAS), row(8'hFF), row_res(BYTE_CLOSE, RES_MEAS),
			// set time with out-of-range digits on hour and minute
			row(BYTE_OPEN), row(CMD_BYTE_TIME), row(ASCII_COLON), row(8'hFF), row(8'hFF),
			row(ASCII_COLON), row(8'h00), row(8'h00), row(ASCII_COLON),
			row(ASCII_ZERO + 8'd5), row(ASCII_ZERO + 8'd9), row(BYTE_CLOSE),
			row(BYTE_OPEN), row(CMD_BYTE_TEMP), row(8'h00), row(8'hFF), row(8'hFF),
			row(ASCII_DOT), row(8'hFF), row_res(BYTE_CLOSE, RES_TEMP_MAX),
			// overlong frame, opening bytes inside it are plain data
			row(BYTE_OPEN), row(CMD_BYTE_TIME), row(BYTE_OPEN), row(BYTE_OPEN),
			row(BYTE_OPEN), row(BYTE_OPEN), row(BYTE_OPEN), row(BYTE_OPEN),
			row(BYTE_OPEN), row(BYTE_OPEN), row(BYTE_OPEN), row(BYTE_OPEN),
			row(BYTE_OPEN), row_res(BYTE_CLOSE, RES_NONE)
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);

		sent = 0;
		while (sent < BYTE_TARGET) begin
			// occasional back-to-back stretches on both channels
			steady = ($urandom_range(0, 4) == 0);
			fill_random_frame(counted);
			foreach (frame_queue[i])
				send_byte(frame_queue[i], 1'b0, RES_NONE);
			sent += counted;
		end
		steady = 1'b0;
		rx_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_results.size() == 0)
			$display("command_frame_parser regression: pass");
		else
			$display("command_frame_parser regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/cfp_pkg.sv
src/cfp_decode.sv
src/command_frame_parser.sv
tb/command_frame_parser_tb.sv
